// File: sv/icsum_pkg.sv
// shared types, register indexes and the checksum fold helper for the internet checksum block
package icsum_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PSEUDO_MODE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDRESS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_NUMBER = 8'd3;

    typedef struct packed {
        logic        word_valid;
        logic [15:0] word;
        logic        last;
        logic [15:0] count;
    } icsum_entry_t;

    // end-around fold of a sum of up to eight 16-bit words
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] t;
        logic [15:0] r;
        t = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        r = t[15:0] + {15'b0, t[16]};
        return r;
    endfunction

endpackage

// File: sv/icsum_if.sv
// handshake channel interfaces for items, results and register writes
interface icsum_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;

    modport source (output valid, data_byte, byte_present, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface icsum_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

interface icsum_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/icsum_front.sv
// front end: pairs bytes into words, counts bytes, marks message ends
module icsum_front
    import icsum_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    icsum_item_if.sink    items,
    input  logic          queue_full,
    output logic          push,
    output icsum_entry_t  entry
);

    logic        odd_reg, odd_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] count_reg, count_next;
    logic        accept;
    logic [15:0] count_new;

    assign items.ready = !queue_full;
    assign accept      = items.valid && items.ready;
    assign count_new   = items.byte_present ? count_reg + 16'd1 : count_reg;

    always_comb
    begin
        entry.word_valid = 1'b0;
        entry.word       = 16'h0000;
        entry.last       = items.last_byte;
        entry.count      = count_new;
        odd_next         = odd_reg;
        held_next        = held_reg;
        if (items.byte_present && odd_reg)
        begin
            entry.word_valid = 1'b1;
            entry.word       = {held_reg, items.data_byte};
            odd_next         = 1'b0;
        end
        else if (items.byte_present)
        begin
            odd_next  = 1'b1;
            held_next = items.data_byte;
            if (items.last_byte)
            begin
                // odd tail padded with a zero low half
                entry.word_valid = 1'b1;
                entry.word       = {items.data_byte, 8'h00};
            end
        end
        else if (items.last_byte && odd_reg)
        begin
            entry.word_valid = 1'b1;
            entry.word       = {held_reg, 8'h00};
        end
        count_next = count_new;
        if (items.last_byte)
        begin
            odd_next   = 1'b0;
            held_next  = 8'h00;
            count_next = 16'h0000;
        end
    end

    assign push = accept && (entry.word_valid || entry.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg   <= 1'b0;
            held_reg  <= 8'h00;
            count_reg <= 16'h0000;
        end
        else if (accept)
        begin
            odd_reg   <= odd_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/icsum_fifo.sv
// short queue of word entries between front and back
module icsum_fifo
    import icsum_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  icsum_entry_t  push_entry,
    input  logic          pop,
    output icsum_entry_t  head,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    icsum_entry_t     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/icsum_back.sv
// back end: ones'-complement accumulate, pseudo-header add, result register, config registers
module icsum_back
    import icsum_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    icsum_cfg_if.sink     cfg,
    input  icsum_entry_t  head,
    input  logic          empty,
    output logic          pop,
    icsum_result_if.source results
);

    logic        pseudo_mode_reg;
    logic [31:0] source_address_reg;
    logic [31:0] dest_address_reg;
    logic [7:0]  protocol_number_reg;
    logic [15:0] psum_reg;

    logic [15:0] acc_reg, acc_next;
    logic        end_valid_reg;
    logic [15:0] end_sum_reg;
    logic [15:0] end_count_reg;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;

    logic        out_free;
    logic        end_move;
    logic        end_free;
    logic [15:0] word_in;
    logic [15:0] pseudo_count;
    logic [15:0] pseudo_fixed;
    logic [15:0] total;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pseudo_mode_reg     <= 1'b0;
            source_address_reg  <= 32'h0;
            dest_address_reg    <= 32'h0;
            protocol_number_reg <= 8'h0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PSEUDO_MODE:     pseudo_mode_reg     <= cfg.data[0];
                REG_SOURCE_ADDRESS:  source_address_reg  <= cfg.data;
                REG_DEST_ADDRESS:    dest_address_reg    <= cfg.data;
                REG_PROTOCOL_NUMBER: protocol_number_reg <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // address and protocol part of the pseudo-header, refreshed every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= 16'h0;
        end
        else
        begin
            psum_reg <= oc_fold({3'b0, source_address_reg[31:16]}
                              + {3'b0, source_address_reg[15:0]}
                              + {3'b0, dest_address_reg[31:16]}
                              + {3'b0, dest_address_reg[15:0]}
                              + {11'b0, protocol_number_reg});
        end
    end

    assign out_free = !out_valid_reg || results.ready;
    assign end_move = end_valid_reg && out_free;
    assign end_free = !end_valid_reg || out_free;
    assign pop      = !empty && end_free;

    assign word_in  = head.word_valid ? head.word : 16'h0;
    assign acc_next = oc_fold({3'b0, acc_reg} + {3'b0, word_in});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 16'h0;
            end_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg <= head.last ? 16'h0 : acc_next;
            end
            if (pop && head.last)
            begin
                end_valid_reg <= 1'b1;
            end
            else if (end_move)
            begin
                end_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            end_sum_reg   <= acc_next;
            end_count_reg <= head.count;
        end
    end

    assign pseudo_count = pseudo_mode_reg ? end_count_reg : 16'h0;
    assign pseudo_fixed = pseudo_mode_reg ? psum_reg : 16'h0;
    assign total        = oc_fold({3'b0, end_sum_reg} + {3'b0, pseudo_count}
                                + {3'b0, pseudo_fixed});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (end_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_move)
        begin
            checksum_reg <= ~total;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.checksum = checksum_reg;

endmodule

// File: sv/internet_checksum_pseudo_header.sv
// top level of the internet checksum block with optional tcp/udp pseudo-header
// throughput: one byte item per cycle while the queue is not full
// the checksum is registered in order: queue write, end-of-message sum register,
// then pseudo-header add into the result register; each step can stall on results.ready
// reset zeroes the running sum, byte pairing, byte count, queue pointers and control registers
module internet_checksum_pseudo_header
    import icsum_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    icsum_item_if.sink      items,
    icsum_result_if.source  results,
    icsum_cfg_if.sink       cfg
);

    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    icsum_entry_t push_entry;
    icsum_entry_t head;

    icsum_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .queue_full (full),
        .push       (push),
        .entry      (push_entry)
    );

    icsum_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    icsum_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .results (results)
    );

endmodule
